### sv/qrs_pkg.sv
package qrs_pkg;

    // field widths
    localparam int CoefW    = 16;
    localparam int ResW     = 32;
    localparam int AbsDW    = 33;
    localparam int RootW    = 32;
    localparam int QuoW     = 33;
    localparam int NbW      = 32;
    localparam int FracSh   = 30;

    // pipeline depths
    localparam int SqrtStages = RootW;
    localparam int DivStages  = QuoW;

    // root classification codes
    localparam logic [1:0] KindDistinct = 2'd0;
    localparam logic [1:0] KindRepeated = 2'd1;
    localparam logic [1:0] KindComplex  = 2'd2;
    localparam logic [1:0] KindInvalid  = 2'd3;

    typedef logic [1:0] t_kind;

    // front end to square root
    typedef struct packed {
        logic                     valid;
        t_kind                    kind;
        logic signed [CoefW-1:0]  a;
        logic signed [NbW-1:0]    nb;
        logic [AbsDW-1:0]         absd;
    } t_front;

    // square root to divider prep
    typedef struct packed {
        logic                     valid;
        t_kind                    kind;
        logic signed [CoefW-1:0]  a;
        logic signed [NbW-1:0]    nb;
        logic [RootW-1:0]         s;
    } t_sq;

    typedef struct packed {
        logic            clip;
        logic [ResW-1:0] val;
    } t_sat;

    // signed quotient from magnitude and sign, clipped to 32 bits
    function automatic t_sat sat_q(input logic [QuoW-1:0] q, input logic neg);
        t_sat r;
        r.clip = 1'b0;
        if (neg) begin
            if (q[32] || (q[31] && (|q[30:0]))) begin
                r.clip = 1'b1;
                r.val  = 32'h8000_0000;
            end else begin
                r.val = 32'(-q[31:0]);
            end
        end else begin
            if (q[32] || q[31]) begin
                r.clip = 1'b1;
                r.val  = 32'h7fff_ffff;
            end else begin
                r.val = q[31:0];
            end
        end
        return r;
    endfunction

endpackage

### sv/qrs_front.sv
module qrs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [qrs_pkg::CoefW-1:0] i_a,
    input  logic signed [qrs_pkg::CoefW-1:0] i_b,
    input  logic signed [qrs_pkg::CoefW-1:0] i_c,
    output qrs_pkg::t_front                  o_front
);

    logic                             r_v;
    logic signed [qrs_pkg::CoefW-1:0] r_a;
    logic signed [qrs_pkg::CoefW-1:0] r_b;
    logic [30:0]                      r_bb;
    logic signed [31:0]               r_ac;
    logic signed [31:0]               w_bb_full;
    logic signed [31:0]               w_ac_full;
    logic signed [34:0]               w_d;
    logic signed [34:0]               w_dabs;
    logic signed [16:0]               w_negb;
    qrs_pkg::t_front                  n_front;
    qrs_pkg::t_front                  r_front;

    // products
    assign w_bb_full = i_b * i_b;
    assign w_ac_full = i_a * i_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_bb <= w_bb_full[30:0];
            r_ac <= w_ac_full;
        end
    end

    // discriminant and classification
    assign w_d    = $signed({4'b0, r_bb}) - $signed({r_ac[31], r_ac, 2'b00});
    assign w_dabs = w_d[34] ? -w_d : w_d;
    assign w_negb = -$signed({r_b[15], r_b});

    always_comb begin
        n_front.valid = r_v;
        n_front.a     = r_a;
        n_front.nb    = $signed({w_negb, 15'b0});
        n_front.absd  = w_dabs[qrs_pkg::AbsDW-1:0];
        if (r_a == '0) begin
            n_front.kind = qrs_pkg::KindInvalid;
        end else if (w_d[34]) begin
            n_front.kind = qrs_pkg::KindComplex;
        end else if (w_d == '0) begin
            n_front.kind = qrs_pkg::KindRepeated;
        end else begin
            n_front.kind = qrs_pkg::KindDistinct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

### sv/qrs_sqrt.sv
module qrs_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  qrs_pkg::t_front i_front,
    output qrs_pkg::t_sq    o_sq
);

    localparam int XW = 2 * qrs_pkg::SqrtStages;
    localparam int RW = qrs_pkg::RootW + 2;

    logic [XW-1:0]             r_x    [qrs_pkg::SqrtStages];
    logic [RW-1:0]             r_rem  [qrs_pkg::SqrtStages];
    logic [qrs_pkg::RootW-1:0] r_root [qrs_pkg::SqrtStages];
    qrs_pkg::t_front           r_side [qrs_pkg::SqrtStages];

    // one result bit per stage, radicand is |d| scaled by 2^30
    for (genvar k = 0; k < qrs_pkg::SqrtStages; k++) begin : g_stage
        logic [XW-1:0]             w_x;
        logic [RW-1:0]             w_rem;
        logic [qrs_pkg::RootW-1:0] w_root;
        qrs_pkg::t_front           w_side;
        logic [RW+1:0]             w_sh;
        logic [RW+1:0]             w_trial;
        logic [RW+1:0]             w_diff;
        logic                      w_ge;

        if (k == 0) begin : g_first
            assign w_x    = {{(XW-qrs_pkg::AbsDW-qrs_pkg::FracSh){1'b0}}, i_front.absd,
                             {qrs_pkg::FracSh{1'b0}}};
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = i_front;
        end else begin : g_next
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_sh    = {w_rem, w_x[XW-1:XW-2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_ge    = (w_sh >= w_trial);
        assign w_diff  = w_sh - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else if (i_en) begin
                r_side[k] <= w_side;
            end
            if (i_en) begin
                r_x[k]    <= {w_x[XW-3:0], 2'b00};
                r_rem[k]  <= w_ge ? w_diff[RW-1:0] : w_sh[RW-1:0];
                r_root[k] <= {w_root[qrs_pkg::RootW-2:0], w_ge};
            end
        end
    end

    assign o_sq.valid = r_side[qrs_pkg::SqrtStages-1].valid;
    assign o_sq.kind  = r_side[qrs_pkg::SqrtStages-1].kind;
    assign o_sq.a     = r_side[qrs_pkg::SqrtStages-1].a;
    assign o_sq.nb    = r_side[qrs_pkg::SqrtStages-1].nb;
    assign o_sq.s     = r_root[qrs_pkg::SqrtStages-1];

endmodule

### sv/qrs_div.sv
module qrs_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [qrs_pkg::QuoW-1:0]   i_num,
    input  logic [qrs_pkg::CoefW-1:0]  i_den,
    input  logic                       i_neg,
    output logic [qrs_pkg::QuoW-1:0]   o_quo,
    output logic                       o_neg
);

    localparam int DW = qrs_pkg::CoefW;

    logic [qrs_pkg::QuoW-1:0] r_num [qrs_pkg::DivStages];
    logic [DW-1:0]            r_rem [qrs_pkg::DivStages];
    logic [DW-1:0]            r_den [qrs_pkg::DivStages];
    logic                     r_neg [qrs_pkg::DivStages];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < qrs_pkg::DivStages; k++) begin : g_stage
        logic [qrs_pkg::QuoW-1:0] w_num;
        logic [DW-1:0]            w_rem;
        logic [DW-1:0]            w_den;
        logic                     w_neg;
        logic [DW:0]              w_sh;
        logic [DW:0]              w_diff;
        logic                     w_ge;

        if (k == 0) begin : g_first
            assign w_num = i_num;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_num = r_num[k-1];
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_neg = r_neg[k-1];
        end

        assign w_sh   = {w_rem, w_num[qrs_pkg::QuoW-1]};
        assign w_ge   = (w_sh >= {1'b0, w_den});
        assign w_diff = w_sh - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {w_num[qrs_pkg::QuoW-2:0], w_ge};
                r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_den[k] <= w_den;
                r_neg[k] <= w_neg;
            end
        end
    end

    assign o_quo = r_num[qrs_pkg::DivStages-1];
    assign o_neg = r_neg[qrs_pkg::DivStages-1];

endmodule

### sv/quadratic_root_solver_core.sv
// quadratic root solver, coefficients a, b, c in signed Q8.8
// input channel: i_valid / o_stall with i_coef_a, i_coef_b, i_coef_c; a request is
// taken on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with the kind code, two real roots, the
// real and imaginary parts of a complex pair and a saturation flag, all roots
// in Q16.16 clipped to 32 bits
// the pipeline runs through a products register, a discriminant register, the square
// root stages (one result bit per stage), a numerator prep register, the two
// dividers' stages (one quotient bit per stage) and an output register
// throughput is one request per cycle while not stalled; the pipeline moves as one unit
// when the receiver holds i_stall with a result waiting, every stage freezes
// and o_stall goes high in the same cycle, so nothing is lost or repeated
// synchronous active-low reset clears all valid bits; no result is pending
// after reset and the block takes a request in the first cycle after it
module quadratic_root_solver_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [qrs_pkg::CoefW-1:0] i_coef_a,
    input  logic signed [qrs_pkg::CoefW-1:0] i_coef_b,
    input  logic signed [qrs_pkg::CoefW-1:0] i_coef_c,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_root_kind,
    output logic signed [qrs_pkg::ResW-1:0]  o_root_one,
    output logic signed [qrs_pkg::ResW-1:0]  o_root_two,
    output logic signed [qrs_pkg::ResW-1:0]  o_real_part,
    output logic signed [qrs_pkg::ResW-1:0]  o_imag_part,
    output logic                             o_saturated
);

    logic                           w_en;
    qrs_pkg::t_front                w_front;
    qrs_pkg::t_sq                   w_sq;
    logic signed [33:0]             w_nb;
    logic signed [33:0]             w_s;
    logic signed [33:0]             w_n0;
    logic signed [33:0]             w_n1;
    logic signed [33:0]             w_a0;
    logic signed [33:0]             w_a1;
    logic signed [qrs_pkg::CoefW:0] w_aext;
    logic signed [qrs_pkg::CoefW:0] w_aabs;
    logic                           r_pv;
    qrs_pkg::t_kind                 r_pkind;
    logic [qrs_pkg::QuoW-1:0]       r_num0;
    logic [qrs_pkg::QuoW-1:0]       r_num1;
    logic [qrs_pkg::CoefW-1:0]      r_den;
    logic                           r_neg0;
    logic                           r_neg1;
    logic [qrs_pkg::QuoW-1:0]       w_q0;
    logic [qrs_pkg::QuoW-1:0]       w_q1;
    logic                           w_qn0;
    logic                           w_qn1;
    logic                           r_dv [qrs_pkg::DivStages];
    qrs_pkg::t_kind                 r_dk [qrs_pkg::DivStages];
    qrs_pkg::t_sat                  w_s0;
    qrs_pkg::t_sat                  w_s1;
    logic                           r_o_valid;
    logic [1:0]                     r_kind;
    logic [qrs_pkg::ResW-1:0]       r_one;
    logic [qrs_pkg::ResW-1:0]       r_two;
    logic [qrs_pkg::ResW-1:0]       r_re;
    logic [qrs_pkg::ResW-1:0]       r_im;
    logic                           r_sat;

    // whole pipeline holds while a result waits on a stalled receiver
    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = !w_en;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_front (w_front)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_front (w_front),
        .o_sq    (w_sq)
    );

    // numerators: nb +/- s for real roots, nb and s for a complex pair
    assign w_nb   = 34'(w_sq.nb);
    assign w_s    = $signed({2'b00, w_sq.s});
    assign w_n0   = (w_sq.kind == qrs_pkg::KindComplex) ? w_nb : (w_nb + w_s);
    assign w_n1   = (w_sq.kind == qrs_pkg::KindComplex) ? w_s : (w_nb - w_s);
    assign w_a0   = w_n0[33] ? -w_n0 : w_n0;
    assign w_a1   = w_n1[33] ? -w_n1 : w_n1;
    assign w_aext = $signed({w_sq.a[qrs_pkg::CoefW-1], w_sq.a});
    assign w_aabs = w_aext[qrs_pkg::CoefW] ? -w_aext : w_aext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= w_sq.valid;
        end
        if (w_en) begin
            r_pkind <= w_sq.kind;
            r_num0  <= w_a0[qrs_pkg::QuoW-1:0];
            r_num1  <= w_a1[qrs_pkg::QuoW-1:0];
            r_den   <= w_aabs[qrs_pkg::CoefW-1:0];
            r_neg0  <= w_n0[33] ^ w_sq.a[qrs_pkg::CoefW-1];
            r_neg1  <= w_n1[33] ^ w_sq.a[qrs_pkg::CoefW-1];
        end
    end

    qrs_div u_div0 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num0),
        .i_den (r_den),
        .i_neg (r_neg0),
        .o_quo (w_q0),
        .o_neg (w_qn0)
    );

    qrs_div u_div1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num1),
        .i_den (r_den),
        .i_neg (r_neg1),
        .o_quo (w_q1),
        .o_neg (w_qn1)
    );

    // valid and kind ride alongside the dividers
    for (genvar k = 0; k < qrs_pkg::DivStages; k++) begin : g_side
        logic           w_v;
        qrs_pkg::t_kind w_k;
        if (k == 0) begin : g_first
            assign w_v = r_pv;
            assign w_k = r_pkind;
        end else begin : g_next
            assign w_v = r_dv[k-1];
            assign w_k = r_dk[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (w_en) begin
                r_dv[k] <= w_v;
            end
            if (w_en) begin
                r_dk[k] <= w_k;
            end
        end
    end

    // saturation and field selection by kind
    assign w_s0 = qrs_pkg::sat_q(w_q0, w_qn0);
    assign w_s1 = qrs_pkg::sat_q(w_q1, w_qn1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_dv[qrs_pkg::DivStages-1];
        end
        if (w_en) begin
            r_kind <= r_dk[qrs_pkg::DivStages-1];
            case (r_dk[qrs_pkg::DivStages-1])
                qrs_pkg::KindDistinct: begin
                    r_one <= w_s0.val;
                    r_two <= w_s1.val;
                    r_re  <= '0;
                    r_im  <= '0;
                    r_sat <= w_s0.clip | w_s1.clip;
                end
                qrs_pkg::KindRepeated: begin
                    r_one <= w_s0.val;
                    r_two <= w_s0.val;
                    r_re  <= '0;
                    r_im  <= '0;
                    r_sat <= w_s0.clip;
                end
                qrs_pkg::KindComplex: begin
                    r_one <= '0;
                    r_two <= '0;
                    r_re  <= w_s0.val;
                    r_im  <= w_s1.val;
                    r_sat <= w_s0.clip | w_s1.clip;
                end
                default: begin
                    r_one <= '0;
                    r_two <= '0;
                    r_re  <= '0;
                    r_im  <= '0;
                    r_sat <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_root_kind = r_kind;
    assign o_root_one  = r_one;
    assign o_root_two  = r_two;
    assign o_real_part = r_re;
    assign o_imag_part = r_im;
    assign o_saturated = r_sat;

    // invalid a yields an all-zero result
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KindInvalid) |->
        (o_root_one == '0 && o_root_two == '0 && o_real_part == '0 &&
         o_imag_part == '0 && !o_saturated))
        else $error("invalid request produced nonzero fields");

    // complex pair leaves the real root fields clear
    a_complex_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KindComplex) |->
        (o_root_one == '0 && o_root_two == '0))
        else $error("complex request produced real roots");

    // repeated root shows in both root fields and no complex part
    a_repeated_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_kind == qrs_pkg::KindRepeated) |->
        (o_root_one == o_root_two && o_real_part == '0 && o_imag_part == '0))
        else $error("repeated root fields disagree");

    // pipeline only holds for a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

endmodule

### tb/qrs_checker.sv
module qrs_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_stall_in,
    input  logic signed [qrs_pkg::CoefW-1:0] i_coef_a,
    input  logic signed [qrs_pkg::CoefW-1:0] i_coef_b,
    input  logic signed [qrs_pkg::CoefW-1:0] i_coef_c,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [1:0]                       i_root_kind,
    input  logic signed [qrs_pkg::ResW-1:0]  i_root_one,
    input  logic signed [qrs_pkg::ResW-1:0]  i_root_two,
    input  logic signed [qrs_pkg::ResW-1:0]  i_real_part,
    input  logic signed [qrs_pkg::ResW-1:0]  i_imag_part,
    input  logic                             i_saturated,
    output int                               o_errors,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        qrs_pkg::t_kind kind;
        logic [31:0]    r1;
        logic [31:0]    r2;
        logic [31:0]    re;
        logic [31:0]    im;
        logic           sat;
    } t_roots;

    t_roots roots_q[$];

    // floor square root of a 64-bit value
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clip32(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // expected roots for one coefficient set
    function automatic t_roots solve_roots(input longint a, input longint b, input longint c);
        t_roots r;
        longint d, nb, s;
        r = '0;
        if (a == 0) begin
            r.kind = qrs_pkg::KindInvalid;
            return r;
        end
        d  = b * b - 4 * a * c;
        nb = -b * 32768;
        if (d > 0) begin
            s      = longint'(int_sqrt(longint'(unsigned'(d)) << 30));
            r.kind = qrs_pkg::KindDistinct;
            r.r1   = clip32((nb + s) / a, r.sat);
            r.r2   = clip32((nb - s) / a, r.sat);
        end else if (d == 0) begin
            r.kind = qrs_pkg::KindRepeated;
            r.r1   = clip32(nb / a, r.sat);
            r.r2   = r.r1;
        end else begin
            s      = longint'(int_sqrt(longint'(unsigned'(-d)) << 30));
            r.kind = qrs_pkg::KindComplex;
            r.re   = clip32(nb / a, r.sat);
            r.im   = clip32(s / a, r.sat);
        end
        return r;
    endfunction

    assign o_pending = roots_q.size();

    // predict on request, compare on result
    always @(posedge i_clk) begin
        t_roots want, got;
        if (i_rst_n && i_valid && !i_stall_in)
            roots_q.push_back(solve_roots(longint'(i_coef_a), longint'(i_coef_b),
                                          longint'(i_coef_c)));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            got = {i_root_kind, i_root_one, i_root_two, i_real_part, i_imag_part,
                   i_saturated};
            if (roots_q.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10) $display("unexpected result %h", got);
            end else begin
                want = roots_q.pop_front();
                if (want !== got) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display({"mismatch kind %0d/%0d r1 %h/%h r2 %h/%h",
                                  " re %h/%h im %h/%h sat %b/%b"},
                                 want.kind, got.kind, want.r1, got.r1, want.r2, got.r2,
                                 want.re, got.re, want.im, got.im, want.sat, got.sat);
                end
            end
        end
    end
endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               valid = 0;
    logic               out_stall = 0;
    logic signed [15:0] coef_a = 0, coef_b = 0, coef_c = 0;
    logic               in_stall, out_valid, saturated;
    logic [1:0]         root_kind;
    logic signed [31:0] root_one, root_two, real_part, imag_part;
    int                 errors, pending;
    int                 idle_pct = 0, stall_pct = 0;

    always #1 clk = ~clk;

    quadratic_root_solver_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(valid), .o_stall(in_stall),
        .i_coef_a(coef_a), .i_coef_b(coef_b), .i_coef_c(coef_c),
        .o_valid(out_valid), .i_stall(out_stall), .o_root_kind(root_kind),
        .o_root_one(root_one), .o_root_two(root_two), .o_real_part(real_part),
        .o_imag_part(imag_part), .o_saturated(saturated));

    qrs_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(valid), .i_stall_in(in_stall),
        .i_coef_a(coef_a), .i_coef_b(coef_b), .i_coef_c(coef_c),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_root_kind(root_kind),
        .i_root_one(root_one), .i_root_two(root_two), .i_real_part(real_part),
        .i_imag_part(imag_part), .i_saturated(saturated),
        .o_errors(errors), .o_pending(pending));

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // one request, with random idle cycles ahead of it; valid stays high after
    // acceptance so a back-to-back request drives it only once per edge
    task automatic send_request(input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] c);
        while ($urandom_range(99) < idle_pct) begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid  <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(512)) - 256);
            3: return 16'($signed($urandom_range(32)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        #200000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        logic [15:0] a, b;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, a zero, repeated, complex, overflow
        send_request(16'h0000, 16'h1234, 16'h0100);
        send_request(16'h0100, 16'hfe00, 16'h0100);
        send_request(16'h0100, 16'h0400, 16'h0400);
        send_request(16'h0100, 16'h0000, 16'h0100);
        send_request(16'h0100, 16'h0000, 16'hff00);
        send_request(16'h0001, 16'h7fff, 16'h0000);
        send_request(16'h0001, 16'h8000, 16'h8000);
        send_request(16'h8000, 16'h8000, 16'h8000);
        send_request(16'h7fff, 16'h7fff, 16'h7fff);
        send_request(16'h8000, 16'h7fff, 16'h7fff);
        send_request(16'hffff, 16'h0001, 16'h7fff);
        send_request(16'hffff, 16'h8000, 16'h0000);
        send_request(16'h0001, 16'h0000, 16'h7fff);
        send_request(16'hff00, 16'h0200, 16'hff00);
        send_request(16'hffff, 16'hffff, 16'hffff);
        valid <= 1'b0;
        // hold off until the pipeline drains
        while (pending != 0) @(posedge clk);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 76) : 0;
            stall_pct = (ph == 2) ? 76 : ((ph == 3) ? 32 : 0);
            for (int n = 0; n < 475; n++) begin
                a = rand_coef();
                b = rand_coef();
                // some sets built for a repeated root: b*b == 4ac with c = b*b/(4a)
                if ($urandom_range(9) == 0) begin
                    a = 16'($urandom_range(8) + 1);
                    b = 16'(2 * $signed(a) * $signed(16'($urandom_range(20)) - 10));
                    send_request(a, b, 16'(($signed(b) * $signed(b)) / (4 * $signed(a))));
                end else begin
                    send_request(a, b, rand_coef());
                end
            end
        end
        valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
